FILE: sv/x86_branch_filter_decoder_top_assert.svh
// Assertion macros for the branch filter decoder checker
`ifndef X86_BRANCH_FILTER_DECODER_TOP_ASSERT_SVH
`define X86_BRANCH_FILTER_DECODER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BFD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bfd_pkg.sv
// Package: constants, command/status structs and helper functions of the branch filter decoder
package bfd_pkg;

    localparam int WIN_LEN          = 5;
    localparam int MAX_WALKBACK_DEF = 4;

    localparam logic [7:0] OP_CALL   = 8'hE8;
    localparam logic [7:0] OP_JMP    = 8'hE9;
    localparam logic [7:0] HIST_KEEP = 8'h77;
    localparam logic [7:0] HIST_CAND = 8'h01;
    localparam logic [7:0] HIST_SIGN = 8'h10;
    localparam logic [7:0] BYTE_ONES = 8'hFF;
    localparam logic [2:0] SKIP_OPND = 3'd4;

    // bit i set where history index i allows a conversion
    localparam logic [7:0] ALLOWED_TAB = 8'b0001_0111;

    typedef struct packed {
        logic load;
        logic cfg_wr;
        logic skip_dec;
        logic gap;
        logic reject;
        logic conv_start;
        logic walk_step;
        logic walk_done;
        logic shift;
        logic restart;
    } bfd_cmd_t;

    typedef struct packed {
        logic full;
        logic skip_nz;
        logic is_cand;
        logic conv_ok;
        logic walk_more;
        logic have_out;
        logic last;
    } bfd_stat_t;

    function automatic logic is_sign(input logic [7:0] b);
        return (b == 8'h00) || (b == BYTE_ONES);
    endfunction

    function automatic logic [1:0] bitnum(input logic [2:0] idx);
        logic [1:0] r;
        unique case (idx)
            3'd0:          r = 2'd0;
            3'd1:          r = 2'd1;
            3'd2, 3'd3:    r = 2'd2;
            default:       r = 2'd3;
        endcase
        return r;
    endfunction

    // shift the history once per byte of gap (gap known to be at most five)
    function automatic logic [7:0] hist_shift(input logic [7:0] m, input logic [2:0] n);
        logic [7:0] r;
        r = m;
        for (int k = 0; k < WIN_LEN; k++) begin
            if (3'(k) < n)
                r = (r & HIST_KEEP) << 1;
        end
        return r;
    endfunction

endpackage

FILE: sv/bfd_ctrl.sv
// Controller state machine of the branch filter decoder
module bfd_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  bfd_pkg::bfd_stat_t  stat,
    output bfd_pkg::bfd_cmd_t   cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_DECIDE = 5'b00100,
        S_WALK   = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        cfg_ready  = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cfg_ready = 1'b1;
                if (cfg_valid)
                begin
                    cmd.cfg_wr = 1'b1;
                end
                else
                begin
                    s_tready = 1'b1;
                    if (s_tvalid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                state_next = S_EMIT;
                if (stat.full)
                begin
                    if (stat.skip_nz)
                    begin
                        cmd.skip_dec = 1'b1;
                    end
                    else if (stat.is_cand)
                    begin
                        cmd.gap    = 1'b1;
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                if (stat.conv_ok)
                begin
                    cmd.conv_start = 1'b1;
                    state_next     = S_WALK;
                end
                else
                begin
                    cmd.reject = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_WALK:
            begin
                if (stat.walk_more)
                begin
                    cmd.walk_step = 1'b1;
                end
                else
                begin
                    cmd.walk_done = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                m_tvalid = stat.have_out;
                if (stat.have_out)
                begin
                    if (m_tready)
                    begin
                        cmd.shift = 1'b1;
                        if (!stat.last)
                            state_next = S_IDLE;
                    end
                end
                else
                begin
                    // no result to offer: restart the stream if its flush finished, else back to idle
                    cmd.restart = stat.last;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: sv/bfd_datapath.sv
// Datapath: byte window, history mask, address conversion and walk-back unit
module bfd_datapath
#(
    parameter int MAX_WALKBACK = bfd_pkg::MAX_WALKBACK_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  bfd_pkg::bfd_cmd_t   cmd,
    output bfd_pkg::bfd_stat_t  stat,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  logic [31:0]         cfg_data,
    output logic [7:0]          out_byte,
    output logic                out_last
);

    localparam int WinLen = bfd_pkg::WIN_LEN;
    localparam int IterW  = $clog2(MAX_WALKBACK + 1);

    logic [7:0]       win_reg  [WinLen];
    logic [7:0]       win_next [WinLen];
    logic [2:0]       fill_reg, fill_next;
    logic [2:0]       skip_reg, skip_next;
    logic [31:0]      head_pos_reg, head_pos_next;
    logic [31:0]      prev_reg, prev_next;
    logic [31:0]      start_reg, start_next;
    logic [7:0]       mask_reg, mask_next;
    logic             last_reg, last_next;
    logic [IterW-1:0] iter_reg, iter_next;
    logic [31:0]      tgt_reg, tgt_next;
    logic [31:0]      dest_reg, dest_next;

    logic [31:0] gap;
    logic [31:0] src;
    logic [31:0] flip;
    logic [7:0]  probe;
    logic [1:0]  bsel;
    logic [2:0]  hidx;

    assign gap  = head_pos_reg - prev_reg;
    assign src  = {win_reg[4], win_reg[3], win_reg[2], win_reg[1]};
    assign hidx = mask_reg[3:1];
    assign bsel = bfd_pkg::bitnum(hidx);

    always_comb
    begin
        case (bsel)
            2'd0:
            begin
                probe = dest_reg[31:24];
                flip  = 32'hFFFF_FFFF;
            end
            2'd1:
            begin
                probe = dest_reg[23:16];
                flip  = 32'h00FF_FFFF;
            end
            2'd2:
            begin
                probe = dest_reg[15:8];
                flip  = 32'h0000_FFFF;
            end
            default:
            begin
                probe = dest_reg[7:0];
                flip  = 32'h0000_00FF;
            end
        endcase
    end

    always_comb
    begin
        stat.full      = (fill_reg == 3'(WinLen));
        stat.skip_nz   = (skip_reg != 3'd0);
        stat.is_cand   = (win_reg[0] == bfd_pkg::OP_CALL) || (win_reg[0] == bfd_pkg::OP_JMP);
        stat.conv_ok   = bfd_pkg::is_sign(win_reg[4]) && bfd_pkg::ALLOWED_TAB[hidx]
                         && (mask_reg[7:5] == 3'd0);
        stat.walk_more = (iter_reg < IterW'(MAX_WALKBACK)) && (mask_reg != 8'h00)
                         && bfd_pkg::is_sign(probe);
        stat.have_out  = last_reg ? (fill_reg != 3'd0) : stat.full;
        stat.last      = last_reg;
    end

    assign out_byte = win_reg[0];
    assign out_last = last_reg && (fill_reg == 3'd1);

    always_comb
    begin
        win_next      = win_reg;
        fill_next     = fill_reg;
        skip_next     = skip_reg;
        head_pos_next = head_pos_reg;
        prev_next     = prev_reg;
        start_next    = start_reg;
        mask_next     = mask_reg;
        last_next     = last_reg;
        iter_next     = iter_reg;
        tgt_next      = tgt_reg;
        dest_next     = dest_reg;

        if (cmd.cfg_wr || cmd.restart)
        begin
            if (cmd.cfg_wr)
                start_next = cfg_data;
            for (int i = 0; i < WinLen; i++)
                win_next[i] = 8'h00;
            fill_next     = 3'd0;
            skip_next     = 3'd0;
            mask_next     = 8'h00;
            last_next     = 1'b0;
            head_pos_next = start_next;
            prev_next     = start_next - 32'(WinLen);
        end

        if (cmd.load)
        begin
            for (int i = 0; i < WinLen; i++)
            begin
                if (3'(i) == fill_reg)
                    win_next[i] = in_byte;
            end
            fill_next = fill_reg + 3'd1;
            last_next = in_last;
        end

        if (cmd.skip_dec)
            skip_next = skip_reg - 3'd1;

        if (cmd.gap)
        begin
            // a gap beyond the window forgets the history
            if (gap > 32'(WinLen))
                mask_next = 8'h00;
            else
                mask_next = bfd_pkg::hist_shift(mask_reg, gap[2:0]);
            prev_next = head_pos_reg;
            tgt_next  = head_pos_reg + 32'(WinLen);
        end

        if (cmd.reject)
        begin
            mask_next = mask_reg | bfd_pkg::HIST_CAND;
            if (bfd_pkg::is_sign(win_reg[4]))
                mask_next = mask_next | bfd_pkg::HIST_SIGN;
        end

        if (cmd.conv_start)
        begin
            dest_next = src - tgt_reg;
            iter_next = IterW'(1);
        end

        if (cmd.walk_step)
        begin
            dest_next = (dest_reg ^ flip) - tgt_reg;
            iter_next = iter_reg + IterW'(1);
        end

        if (cmd.walk_done)
        begin
            win_next[4] = dest_reg[24] ? bfd_pkg::BYTE_ONES : 8'h00;
            win_next[3] = dest_reg[23:16];
            win_next[2] = dest_reg[15:8];
            win_next[1] = dest_reg[7:0];
            skip_next   = bfd_pkg::SKIP_OPND;
            mask_next   = 8'h00;
        end

        if (cmd.shift)
        begin
            for (int i = 0; i < WinLen - 1; i++)
                win_next[i] = win_reg[i+1];
            win_next[WinLen-1] = 8'h00;
            fill_next          = fill_reg - 3'd1;
            head_pos_next      = head_pos_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= 3'd0;
            skip_reg     <= 3'd0;
            head_pos_reg <= 32'd0;
            prev_reg     <= 32'd0 - 32'(WinLen);
            start_reg    <= 32'd0;
            mask_reg     <= 8'h00;
            last_reg     <= 1'b0;
            iter_reg     <= '0;
        end
        else
        begin
            fill_reg     <= fill_next;
            skip_reg     <= skip_next;
            head_pos_reg <= head_pos_next;
            prev_reg     <= prev_next;
            start_reg    <= start_next;
            mask_reg     <= mask_next;
            last_reg     <= last_next;
            iter_reg     <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        tgt_reg  <= tgt_next;
        dest_reg <= dest_next;
    end

endmodule

FILE: sv/x86_branch_filter_decoder_top.sv
// A byte is taken in S_IDLE and tested in S_CHECK the cycle after; a result beat is offered in S_EMIT
// once the window is full. Bytes are taken one at a time: the next only back in S_IDLE. A rejected E8/E9
//   candidate passes S_DECIDE, a converted one S_DECIDE and S_WALK (one walk-back step per cycle).
// End of stream: one beat per buffered byte (up to five), then the stream restarts from start_position.
// Reset: rst_n asynchronous, active low; empties the window (fill count to 0), clears the history, start_position to 0.
// Top level of the x86 branch filter decoder
module x86_branch_filter_decoder_top
#(
    parameter int MAX_WALKBACK = bfd_pkg::MAX_WALKBACK_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    bfd_pkg::bfd_cmd_t  cmd;
    bfd_pkg::bfd_stat_t stat;

    bfd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bfd_datapath #(
        .MAX_WALKBACK (MAX_WALKBACK)
    ) u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .cfg_data (cfg_data),
        .out_byte (m_tdata),
        .out_last (m_tlast)
    );

endmodule

FILE: sv/bfd_checker.sv
// Port-level checker of the branch filter decoder, bound to the top level
`include "x86_branch_filter_decoder_top_assert.svh"

module bfd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    `BFD_ASSERT_IMP(a_no_in_while_out, s_tvalid && s_tready, !m_tvalid, "input beat taken while a result is offered")
    `BFD_ASSERT_IMP(a_cfg_in_apart, cfg_valid && cfg_ready, !(s_tvalid && s_tready), "config write and input beat in one cycle")
    `BFD_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second input beat before the first was handled")
    `BFD_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result beat changed")
    `BFD_ASSERT_NXT(a_last_ends, m_tvalid && m_tready && m_tlast, !m_tvalid, "result beat after the end of the stream")

endmodule

bind x86_branch_filter_decoder_top bfd_checker u_bfd_checker (.*);
